// ===== sv/dms_pkg.sv =====
// ----------------------------------------------------------------------------
// dms_pkg
// Shared types, codes and reset constants of the dispense motor sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dms_pkg;

  // status word period in ticks
  localparam int unsigned STATUS_PERIOD_DEF = 200;

  // field widths
  localparam int unsigned ID_W      = 11;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned MINRUN_W  = 12;
  localparam int unsigned TMO_W     = 13;
  localparam int unsigned SETTLE_W  = 7;
  localparam int unsigned HOLD_W    = 12;
  localparam int unsigned CHECK_W   = 8;
  localparam int unsigned RUN_W     = 14;
  localparam int unsigned DONE_W    = 8;
  localparam int unsigned BTNCNT_W  = 12;
  localparam int unsigned TDIV_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 13;
  localparam int unsigned S_DATA_W  = 24;
  localparam int unsigned M_DATA_W  = 16;

  // register reset values
  localparam logic [ID_W-1:0]     BASE_ID_RST   = 11'd288;
  localparam logic [MINRUN_W-1:0] MIN_RUN_RST   = 12'd1000;
  localparam logic [TMO_W-1:0]    TIMEOUT_RST   = 13'd5000;
  localparam logic [SETTLE_W-1:0] SETTLE_RST    = 7'd100;
  localparam logic [HOLD_W-1:0]   HOLD_RST      = 12'd1000;
  localparam logic [CHECK_W-1:0]  CHECK_CNT_RST = 8'd10;
  localparam logic [RUN_W-1:0]    RUN_TMR_RST   = 14'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOARD    = 3'd0,
    CFG_CHANNEL  = 3'd1,
    CFG_BASE_ID  = 3'd2,
    CFG_MIN_RUN  = 3'd3,
    CFG_TIMEOUT  = 3'd4,
    CFG_SETTLE   = 3'd5,
    CFG_HOLD     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_PRECHECK = 2'd1,
    PH_RUN      = 2'd2,
    PH_CONFIRM  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_BUSY     = 3'd1,
    ERR_CUP      = 3'd2,
    ERR_FAIL     = 3'd3,
    ERR_TIMEOUT  = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    BTN_RELEASED = 2'd0,
    BTN_COUNTING = 2'd1,
    BTN_LATCHED  = 2'd2
  } btn_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_FRAME = 1'b1
  } op_e;

  typedef struct packed {
    logic [1:0]          board;
    logic                channel;
    logic [ID_W-1:0]     base_id;
    logic [MINRUN_W-1:0] min_run;
    logic [TMO_W-1:0]    timeout;
    logic [SETTLE_W-1:0] settle;
    logic [HOLD_W-1:0]   hold;
  } cfg_t;

  typedef struct packed {
    op_e               opcode;
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] first_byte;
    logic              cup_sensor_low;
    logic              rotate_limit;
    logic              button_pressed;
  } item_t;

  typedef struct packed {
    phase_e                   phase;
    logic signed [CHECK_W-1:0] check_cnt;
    logic signed [RUN_W-1:0]  run_tmr;
    err_e                     err;
    logic [DONE_W-1:0]        done_cnt;
    logic                     motor;
    btn_e                     btn;
    logic [BTNCNT_W-1:0]      btn_cnt;
    logic [TDIV_W-1:0]        tick_div;
    logic                     cup;
  } state_t;

  typedef struct packed {
    logic              status_due;
    logic              cup_present;
    logic              motor_on;
    logic [DONE_W-1:0] completion_count;
    err_e              last_error;
    phase_e            phase;
  } result_t;

endpackage

`default_nettype wire

// ===== sv/dms_cfg.sv =====
// ----------------------------------------------------------------------------
// dms_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_cfg
  import dms_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i,
  output cfg_t                      cfg_o
);

  cfg_t cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.board   <= '0;
      cfg_q.channel <= 1'b0;
      cfg_q.base_id <= BASE_ID_RST;
      cfg_q.min_run <= MIN_RUN_RST;
      cfg_q.timeout <= TIMEOUT_RST;
      cfg_q.settle  <= SETTLE_RST;
      cfg_q.hold    <= HOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_BOARD:   cfg_q.board   <= cfg_data_i[1:0];
        CFG_CHANNEL: cfg_q.channel <= cfg_data_i[0];
        CFG_BASE_ID: cfg_q.base_id <= cfg_data_i[ID_W-1:0];
        CFG_MIN_RUN: cfg_q.min_run <= cfg_data_i[MINRUN_W-1:0];
        CFG_TIMEOUT: cfg_q.timeout <= cfg_data_i[TMO_W-1:0];
        CFG_SETTLE:  cfg_q.settle  <= cfg_data_i[SETTLE_W-1:0];
        CFG_HOLD:    cfg_q.hold    <= cfg_data_i[HOLD_W-1:0];
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== sv/dms_step.sv =====
// ----------------------------------------------------------------------------
// dms_step
// Next-state and result logic for one tick or frame item.
// ----------------------------------------------------------------------------
`default_nettype none

module dms_step
  import dms_pkg::*;
#(
  parameter int unsigned STATUS_PERIOD = STATUS_PERIOD_DEF
) (
  input  wire cfg_t    cfg_i,
  input  wire item_t   item_i,
  input  wire state_t  state_i,
  output state_t  state_o,
  output result_t result_o
);

  localparam logic signed [CHECK_W-1:0] CHECK_MIN = {1'b1, {(CHECK_W-1){1'b0}}};
  localparam logic signed [RUN_W-1:0]   RUN_MIN   = {1'b1, {(RUN_W-1){1'b0}}};
  localparam logic [TDIV_W-1:0]         PERIOD    = TDIV_W'(STATUS_PERIOD);

  logic [ID_W:0]             want_id;
  logic                      cmd_hit;
  logic [BTNCNT_W-1:0]       btn_inc;
  logic signed [CHECK_W-1:0] check_dec;
  logic signed [RUN_W-1:0]   run_dec;
  logic signed [RUN_W:0]     run_ext;
  logic signed [RUN_W:0]     tmo_neg;
  logic [TDIV_W-1:0]         tdiv_inc;
  logic                      due;
  state_t                    s;

  // command identifier, compared without wrap
  assign want_id = {1'b0, cfg_i.base_id} + {{(ID_W-2){1'b0}}, cfg_i.board, 1'b0}
                 + {{ID_W{1'b0}}, cfg_i.channel};
  assign cmd_hit = ({1'b0, item_i.frame_id} == want_id) && (item_i.first_byte == '0);

  always_comb begin
    s         = state_i;
    due       = 1'b0;
    btn_inc   = '0;
    check_dec = '0;
    run_dec   = '0;
    run_ext   = '0;
    tmo_neg   = '0;
    tdiv_inc  = '0;

    if (item_i.opcode == OP_FRAME) begin
      // dispense command frame
      if (cmd_hit) begin
        if (s.phase == PH_IDLE) begin
          s.check_cnt = $signed({1'b0, cfg_i.settle});
          s.run_tmr   = $signed({2'b00, cfg_i.min_run});
          s.phase     = PH_PRECHECK;
        end else begin
          s.err      = ERR_BUSY;
          s.done_cnt = s.done_cnt + 1'b1;
        end
      end
    end else begin
      // manual button long press
      if (item_i.button_pressed) begin
        if (s.btn == BTN_COUNTING) begin
          btn_inc   = (s.btn_cnt != '1) ? s.btn_cnt + 1'b1 : s.btn_cnt;
          s.btn_cnt = btn_inc;
          if (btn_inc >= cfg_i.hold) begin
            s.btn     = BTN_LATCHED;
            s.run_tmr = $signed({2'b00, cfg_i.min_run});
            s.phase   = PH_PRECHECK;
          end
        end
        if (s.btn == BTN_RELEASED) begin
          s.btn = BTN_COUNTING;
        end
      end else begin
        s.btn     = BTN_RELEASED;
        s.btn_cnt = '0;
      end

      // cup sense
      s.cup = ~item_i.cup_sensor_low;

      // saturating down counts
      check_dec = (s.check_cnt != CHECK_MIN) ? s.check_cnt - 1'b1 : s.check_cnt;
      run_dec   = (s.run_tmr != RUN_MIN) ? s.run_tmr - 1'b1 : s.run_tmr;
      run_ext   = {run_dec[RUN_W-1], run_dec};
      tmo_neg   = $signed((RUN_W+1)'(0) - {2'b00, cfg_i.timeout});

      // dispense phases
      unique case (s.phase)
        PH_PRECHECK: begin
          s.check_cnt = check_dec;
          if (check_dec[CHECK_W-1]) begin
            s.phase = PH_RUN;
          end else if (!item_i.cup_sensor_low) begin
            s.err      = ERR_CUP;
            s.done_cnt = s.done_cnt + 1'b1;
            s.phase    = PH_IDLE;
          end
        end
        PH_RUN: begin
          s.motor   = 1'b1;
          s.run_tmr = run_dec;
          if (run_dec[RUN_W-1]) begin
            if (!item_i.rotate_limit) begin
              s.motor     = 1'b0;
              s.check_cnt = $signed({1'b0, cfg_i.settle});
              s.phase     = PH_CONFIRM;
            end else if (run_ext < tmo_neg) begin
              s.motor    = 1'b0;
              s.err      = ERR_TIMEOUT;
              s.done_cnt = s.done_cnt + 1'b1;
              s.phase    = PH_IDLE;
            end
          end
        end
        PH_CONFIRM: begin
          s.check_cnt = check_dec;
          if (check_dec[CHECK_W-1]) begin
            s.err      = ERR_NONE;
            s.done_cnt = s.done_cnt + 1'b1;
            s.phase    = PH_IDLE;
          end else if (item_i.cup_sensor_low) begin
            s.err      = ERR_FAIL;
            s.done_cnt = s.done_cnt + 1'b1;
            s.phase    = PH_IDLE;
          end
        end
        default: begin
          s.phase = PH_IDLE;
        end
      endcase

      // status period
      tdiv_inc = s.tick_div + 1'b1;
      if (tdiv_inc >= PERIOD) begin
        s.tick_div = '0;
        due        = 1'b1;
      end else begin
        s.tick_div = tdiv_inc;
      end
    end
  end

  assign state_o = s;

  // result word
  assign result_o.phase            = s.phase;
  assign result_o.last_error       = s.err;
  assign result_o.completion_count = s.done_cnt;
  assign result_o.motor_on         = s.motor;
  assign result_o.cup_present      = s.cup;
  assign result_o.status_due       = due;

endmodule

`default_nettype wire

// ===== sv/dispense_motor_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// dispense_motor_sequencer_core
// One dispense channel: button qualify, cup checks, motor run and status tick.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tuser: opcode; tdata: frame_id, first_byte, sensors, button
//  m_axis    out  tdata: phase, last_error, completion_count, motor, cup, due
//  cfg       in   write enable, register index, write data
//
//  An item is held in the input register, then the step logic updates the
//  channel state and loads the result register.
//  One item per cycle is sustained while m_axis_tready is high; the result register decouples the sides.
//  m_axis_tready low holds the result and back-pressures only once both
//  registers are full. Reset clears the channel state, config registers and valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module dispense_motor_sequencer_core
  import dms_pkg::*;
#(
  parameter int unsigned STATUS_PERIOD = STATUS_PERIOD_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // frame_id[10:0], first_byte[18:11], cup_sensor_low[19], rotate_limit[20],
  // button_pressed[21], zero[23:22]
  input  wire logic [S_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  wire logic                 s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // phase[1:0], last_error[4:2], completion_count[12:5], motor_on[13],
  // cup_present[14], status_due[15]
  output logic [M_DATA_W-1:0]       m_axis_tdata,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   in_q;
  logic    in_vld_q;
  result_t out_q;
  logic    out_vld_q;
  state_t  state_q;
  state_t  state_d;
  result_t res_d;
  logic    advance;

  dms_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dms_step #(
    .STATUS_PERIOD (STATUS_PERIOD)
  ) u_step (
    .cfg_i    (cfg),
    .item_i   (in_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // handshake
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.opcode         <= op_e'(s_axis_tuser);
      in_q.frame_id       <= s_axis_tdata[10:0];
      in_q.first_byte     <= s_axis_tdata[18:11];
      in_q.cup_sensor_low <= s_axis_tdata[19];
      in_q.rotate_limit   <= s_axis_tdata[20];
      in_q.button_pressed <= s_axis_tdata[21];
    end
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase     <= PH_IDLE;
      state_q.check_cnt <= $signed(CHECK_CNT_RST);
      state_q.run_tmr   <= $signed(RUN_TMR_RST);
      state_q.err       <= ERR_NONE;
      state_q.done_cnt  <= '0;
      state_q.motor     <= 1'b0;
      state_q.btn       <= BTN_RELEASED;
      state_q.btn_cnt   <= '0;
      state_q.tick_div  <= '0;
      state_q.cup       <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // checks
  a_tdiv_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.tick_div < TDIV_W'(STATUS_PERIOD))
    else $error("tick divider out of range");

  a_err_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.err == ERR_NONE || state_q.err == ERR_BUSY || state_q.err == ERR_CUP ||
    state_q.err == ERR_FAIL || state_q.err == ERR_TIMEOUT)
    else $error("error code out of range");

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without an item");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free register");

  a_frame_no_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.opcode == OP_FRAME |=> !m_axis_tdata[15])
    else $error("status due raised on a frame");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for one dispense channel. A short table of ticks,
// frames and register writes comes first, then random runs over several
// register settings and one motor run with the limit never reached out to
// its timeout. Every accepted input word is run through a bit-accurate
// channel predictor, and each output word is checked against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dms_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;

  // dut ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_DATA_W-1:0]  s_axis_tdata;
  logic                 s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_DATA_W-1:0]  m_axis_tdata;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  // predictor copy of the registers
  logic [1:0]          cfg_board   = '0;
  logic                cfg_chan    = 1'b0;
  logic [ID_W-1:0]     cfg_base    = BASE_ID_RST;
  logic [MINRUN_W-1:0] cfg_min_run = MIN_RUN_RST;
  logic [TMO_W-1:0]    cfg_timeout = TIMEOUT_RST;
  logic [SETTLE_W-1:0] cfg_settle  = SETTLE_RST;
  logic [HOLD_W-1:0]   cfg_hold    = HOLD_RST;

  // predictor copy of the channel state
  phase_e                    ph_q      = PH_IDLE;
  logic signed [CHECK_W-1:0] chk_q     = CHECK_CNT_RST;
  logic signed [RUN_W-1:0]   run_q     = RUN_TMR_RST;
  err_e                      err_q     = ERR_NONE;
  logic [DONE_W-1:0]         done_q    = '0;
  logic                      motor_q   = 1'b0;
  btn_e                      btn_q     = BTN_RELEASED;
  logic [BTNCNT_W-1:0]       btn_cnt_q = '0;
  logic [TDIV_W-1:0]         tdiv_q    = '0;
  logic                      cup_q     = 1'b0;

  // directed table row: either a register write or one input word
  typedef struct {
    bit       is_cfg;
    cfg_idx_e idx;
    int       val;
    item_t    it;
    bit       typed;
    result_t  want;
  } plan_row_t;

  plan_row_t plan[$];
  result_t   pending_results[$];
  int        fails     = 0;
  int        cycle_cnt = 0;
  bit        tx_burst  = 1'b0;
  bit        rx_burst  = 1'b0;
  bit        btn_held  = 1'b0;

  dispense_motor_sequencer_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d words outstanding", $time,
               pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic item_t mk_item(input op_e op, input logic [ID_W-1:0] id,
                                    input logic [BYTE_W-1:0] byt, input logic sensor,
                                    input logic limit, input logic pressed);
    item_t it;
    it.opcode         = op;
    it.frame_id       = id;
    it.first_byte     = byt;
    it.cup_sensor_low = sensor;
    it.rotate_limit   = limit;
    it.button_pressed = pressed;
    return it;
  endfunction

  function automatic result_t res(input phase_e ph, input err_e code, input int cnt,
                                  input int cup);
    result_t r;
    r.phase            = ph;
    r.last_error       = code;
    r.completion_count = DONE_W'(cnt);
    r.motor_on         = 1'b0;
    r.cup_present      = 1'(cup);
    r.status_due       = 1'b0;
    return r;
  endfunction

  function automatic void add_item(input op_e op, input int id, input int byt,
                                   input int sensor, input int limit,
                                   input int pressed, input int typed,
                                   input result_t want);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx    = CFG_BOARD;
    row.val    = 0;
    row.it     = mk_item(op, ID_W'(id), BYTE_W'(byt), 1'(sensor), 1'(limit),
                         1'(pressed));
    row.typed  = (typed != 0);
    row.want   = want;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input cfg_idx_e idx, input int val);
    plan_row_t row;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    row.it     = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    plan.push_back(row);
  endfunction

  // request closes with an error code
  function automatic void close_request(input err_e code);
    err_q  = code;
    done_q = done_q + 1'b1;
    ph_q   = PH_IDLE;
  endfunction

  // channel predictor: one input word in, one output word out
  function automatic result_t channel_step(input item_t it);
    result_t r;
    int      cmd_id;
    logic    due;
    due = 1'b0;
    if (it.opcode == OP_FRAME) begin
      // id sum is compared unwrapped
      cmd_id = int'(cfg_base) + 2 * int'(cfg_board) + int'(cfg_chan);
      if (int'(it.frame_id) == cmd_id && it.first_byte == '0) begin
        if (ph_q == PH_IDLE) begin
          chk_q = CHECK_W'(cfg_settle);
          run_q = RUN_W'(cfg_min_run);
          ph_q  = PH_PRECHECK;
        end else begin
          err_q  = ERR_BUSY;
          done_q = done_q + 1'b1;
        end
      end
    end else begin
      // long press qualification, manual start loads only the run timer
      if (it.button_pressed) begin
        if (btn_q == BTN_COUNTING) begin
          if (btn_cnt_q != '1) btn_cnt_q = btn_cnt_q + 1'b1;
          if (btn_cnt_q >= cfg_hold) begin
            btn_q = BTN_LATCHED;
            run_q = RUN_W'(cfg_min_run);
            ph_q  = PH_PRECHECK;
          end
        end
        if (btn_q == BTN_RELEASED) btn_q = BTN_COUNTING;
      end else begin
        btn_q     = BTN_RELEASED;
        btn_cnt_q = '0;
      end

      cup_q = !it.cup_sensor_low;

      // dispense phases
      case (ph_q)
        PH_PRECHECK: begin
          if (int'(chk_q) > -128) chk_q = chk_q - 1'b1;
          if (chk_q < 0) ph_q = PH_RUN;
          else if (!it.cup_sensor_low) close_request(ERR_CUP);
        end
        PH_RUN: begin
          motor_q = 1'b1;
          if (int'(run_q) > -8192) run_q = run_q - 1'b1;
          if (run_q < 0) begin
            if (!it.rotate_limit) begin
              motor_q = 1'b0;
              chk_q   = CHECK_W'(cfg_settle);
              ph_q    = PH_CONFIRM;
            end else if (int'(run_q) < -int'(cfg_timeout)) begin
              motor_q = 1'b0;
              close_request(ERR_TIMEOUT);
            end
          end
        end
        PH_CONFIRM: begin
          if (int'(chk_q) > -128) chk_q = chk_q - 1'b1;
          if (chk_q < 0) close_request(ERR_NONE);
          else if (it.cup_sensor_low) close_request(ERR_FAIL);
        end
        default: ;
      endcase

      // status period
      tdiv_q = tdiv_q + 1'b1;
      if (tdiv_q >= STATUS_PERIOD_DEF) begin
        tdiv_q = '0;
        due    = 1'b1;
      end
    end

    r.phase            = ph_q;
    r.last_error       = err_q;
    r.completion_count = done_q;
    r.motor_on         = motor_q;
    r.cup_present      = cup_q;
    r.status_due       = due;
    return r;
  endfunction

  // random word, mostly shaped to walk a dispense through its phases
  function automatic item_t draw_item();
    item_t it;
    int    roll;
    int    cmd_id;
    roll   = $urandom_range(0, 99);
    cmd_id = int'(cfg_base) + 2 * int'(cfg_board) + int'(cfg_chan);
    it = mk_item(OP_TICK, ID_W'($urandom), BYTE_W'($urandom), 1'($urandom),
                 1'($urandom), 1'($urandom));
    if (roll < 12) begin
      it.opcode = op_e'($urandom_range(0, 1));
      return it;
    end
    if (roll < 24) begin
      // command frame, sometimes malformed
      it.opcode = OP_FRAME;
      if (cmd_id <= 2047) it.frame_id = ID_W'(cmd_id);
      if ($urandom_range(0, 3) != 0) it.first_byte = '0;
      if ($urandom_range(0, 7) == 0) it.frame_id[$urandom_range(0, ID_W-1)] ^= 1'b1;
      return it;
    end
    if ($urandom_range(0, 11) == 0) btn_held = !btn_held;
    it.button_pressed = btn_held;
    case (ph_q)
      PH_PRECHECK: it.cup_sensor_low = ($urandom_range(0, 24) != 0);
      PH_RUN:      it.rotate_limit   = ($urandom_range(0, 9) != 0);
      PH_CONFIRM:  it.cup_sensor_low = ($urandom_range(0, 24) == 0);
      default: ;
    endcase
    return it;
  endfunction

  // check one output word against the oldest prediction
  function automatic void check_word(input result_t got);
    result_t want;
    if (pending_results.size() == 0) begin
      fails++;
      $display("%0t: unexpected word, expected none, actual %h", $time, got);
      return;
    end
    want = pending_results.pop_front();
    if (got.phase !== want.phase || got.last_error !== want.last_error ||
        got.completion_count !== want.completion_count ||
        got.motor_on !== want.motor_on || got.cup_present !== want.cup_present ||
        got.status_due !== want.status_due) begin
      fails++;
      $display({"%0t: mismatch, expected ph %0d err %0d cnt %0d mot %b cup %b due %b,",
                " actual ph %0d err %0d cnt %0d mot %b cup %b due %b"}, $time,
               want.phase, want.last_error, want.completion_count, want.motor_on,
               want.cup_present, want.status_due, got.phase, got.last_error,
               got.completion_count, got.motor_on, got.cup_present, got.status_due);
    end
  endfunction

  // offer one word, predict it once accepted, then idle for a drawn gap
  task automatic send_word(input item_t it, input bit typed, input result_t want);
    result_t predicted;
    int      gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.button_pressed, it.rotate_limit, it.cup_sensor_low,
                      it.first_byte, it.frame_id};
    s_axis_tuser  <= it.opcode;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = channel_step(it);
    pending_results.push_back(typed ? want : predicted);
    if ($urandom_range(0, 29) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DAT_W'(val);
    @(posedge clk_i);
    case (idx)
      CFG_BOARD:   cfg_board   = 2'(val);
      CFG_CHANNEL: cfg_chan    = 1'(val);
      CFG_BASE_ID: cfg_base    = ID_W'(val);
      CFG_MIN_RUN: cfg_min_run = MINRUN_W'(val);
      CFG_TIMEOUT: cfg_timeout = TMO_W'(val);
      CFG_SETTLE:  cfg_settle  = SETTLE_W'(val);
      CFG_HOLD:    cfg_hold    = HOLD_W'(val);
      default: ;
    endcase
  endtask

  task automatic load_settings(input int board, input int chan, input int base,
                               input int min_run, input int tmo, input int settle,
                               input int hold);
    drain();
    write_reg(CFG_BOARD, board);
    write_reg(CFG_CHANNEL, chan);
    write_reg(CFG_BASE_ID, base);
    write_reg(CFG_MIN_RUN, min_run);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_HOLD, hold);
    cfg_we_i <= 1'b0;
  endtask

  // output side: random hold-off per word, one long stall
  initial begin : sink
    int hold_off;
    int words;
    hold_off = 0;
    words    = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        check_word(result_t'(m_axis_tdata));
        words++;
        if ($urandom_range(0, 29) == 0) rx_burst = !rx_burst;
        hold_off = rx_burst ? 0 : $urandom_range(0, 14);
        if (words == 400) hold_off = 300;
      end else if (hold_off != 0) begin
        hold_off--;
      end
      m_axis_tready <= (hold_off == 0);
    end
  end

  // input side and run control
  initial begin : stimulus
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_BOARD;
    cfg_data_i    <= '0;

    // reset values, ignored fields, near-miss frames, busy and cup errors
    add_item(OP_TICK,  2047, 255, 1, 1, 0, 1, res(PH_IDLE, ERR_NONE, 0, 0));
    add_item(OP_TICK,     0,   0, 0, 0, 0, 1, res(PH_IDLE, ERR_NONE, 0, 1));
    add_item(OP_FRAME,  288, 255, 1, 1, 1, 1, res(PH_IDLE, ERR_NONE, 0, 1));
    add_item(OP_FRAME,  289,   0, 0, 0, 0, 1, res(PH_IDLE, ERR_NONE, 0, 1));
    add_item(OP_FRAME,    0,   0, 1, 1, 1, 1, res(PH_IDLE, ERR_NONE, 0, 1));
    add_item(OP_FRAME, 2047,   0, 0, 0, 0, 1, res(PH_IDLE, ERR_NONE, 0, 1));
    add_item(OP_FRAME,  288,   0, 0, 0, 1, 1, res(PH_PRECHECK, ERR_NONE, 0, 1));
    add_item(OP_FRAME,  288,   0, 1, 1, 0, 1, res(PH_PRECHECK, ERR_BUSY, 1, 1));
    add_item(OP_TICK,     0,   0, 1, 1, 0, 1, res(PH_PRECHECK, ERR_BUSY, 1, 0));
    add_item(OP_TICK,     0,   0, 0, 1, 0, 1, res(PH_IDLE, ERR_CUP, 2, 1));
    add_item(OP_FRAME,  288,   0, 0, 0, 0, 1, res(PH_PRECHECK, ERR_CUP, 2, 1));
    add_item(OP_TICK,  2047, 255, 1, 1, 1, 1, res(PH_PRECHECK, ERR_CUP, 2, 0));
    add_item(OP_TICK,     0,   0, 1, 1, 1, 0, '0);
    add_item(OP_TICK,     0,   0, 0, 1, 0, 0, '0);
    // command id sum past the id range never matches
    add_cfg(CFG_BOARD, 3);
    add_cfg(CFG_CHANNEL, 1);
    add_cfg(CFG_BASE_ID, 2047);
    add_cfg(CFG_SETTLE, 0);
    add_cfg(CFG_MIN_RUN, 0);
    add_cfg(CFG_TIMEOUT, 0);
    add_cfg(CFG_HOLD, 0);
    add_item(OP_FRAME,    6,   0, 1, 1, 0, 0, '0);
    add_item(OP_FRAME, 2047,   0, 1, 1, 0, 0, '0);
    // zero timings: immediate timeout, manual start on second pressed tick
    add_cfg(CFG_BASE_ID, 100);
    add_item(OP_FRAME,  107,   0, 1, 1, 0, 0, '0);
    add_item(OP_TICK,     0,   0, 1, 1, 0, 0, '0);
    add_item(OP_TICK,     0,   0, 1, 1, 0, 0, '0);
    add_item(OP_TICK,     0,   0, 1, 1, 1, 0, '0);
    add_item(OP_TICK,     0,   0, 1, 1, 1, 0, '0);
    add_item(OP_TICK,     0,   0, 1, 0, 1, 0, '0);
    add_item(OP_TICK,     0,   0, 0, 0, 1, 0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
        cfg_we_i <= 1'b0;
      end else begin
        send_word(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    // random runs: zero extremes, top extremes, then short random timings
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: load_settings(0, 0, 0, 0, 0, 0, 0);
        1: load_settings(3, 1, 2040, 4095, 8191, 127, 4095);
        default: load_settings($urandom_range(0, 3), $urandom_range(0, 1),
                               $urandom_range(0, 2047), $urandom_range(0, 15),
                               $urandom_range(0, 25), $urandom_range(0, 10),
                               $urandom_range(0, 8));
      endcase
      repeat (100) send_word(draw_item(), 1'b0, '0);
    end

    // motor run with the limit never reached, out to its timeout
    load_settings(0, 0, 288, 0, 40, 0, 1);
    send_word(mk_item(OP_FRAME, ID_W'(288), '0, 1'b1, 1'b1, 1'b0), 1'b0, '0);
    repeat (50) send_word(mk_item(OP_TICK, '0, '0, 1'b1, 1'b1, 1'b0), 1'b0, '0);

    drain();
    if (fails == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
